// File: rtl/sjsr_pkg.sv
// ----------------------------------------------------------------------------
// sjsr_pkg: shared types and constants for the six joint servo ramp
// Holds position and step types, item and register codes, clamp limits,
// reset values and the per-joint goal bias used by the goal conversion.
// ----------------------------------------------------------------------------
package sjsr_pkg;

  localparam int NUM_JOINTS  = 6;
  localparam int NUM_STEPPED = 4;

  typedef logic [10:0] pos_t;
  typedef logic [7:0]  step_t;
  typedef logic [2:0]  joint_t;
  typedef logic [2:0]  cfg_idx_t;

  // Item codes.
  localparam logic OP_TICK     = 1'b0;
  localparam logic OP_SET_GOAL = 1'b1;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_STEP_TURN   = 3'd0;
  localparam cfg_idx_t CFG_STEP_BIG    = 3'd1;
  localparam cfg_idx_t CFG_STEP_MEDIUM = 3'd2;
  localparam cfg_idx_t CFG_STEP_SMALL  = 3'd3;

  localparam joint_t GRIPPER     = 3'd5;
  localparam joint_t JOINT_LIMIT = 3'd6;

  localparam pos_t BASE_POS  = 11'd700;
  localparam pos_t GRIP_MIN  = 11'd450;
  localparam pos_t GRIP_MAX  = 11'd1000;
  localparam pos_t JOINT_MIN = 11'd200;
  localparam pos_t JOINT_MAX = 11'd1200;

  localparam logic [8:0] FINE_MARGIN = 9'd5;

  // Reciprocal of three in 17 fractional bits, exact for dividends below 2^17.
  localparam logic [16:0] RECIP3     = 17'd43691;
  localparam int          RECIP3_SHR = 17;
  // Bias that makes the dividend non-negative: 4098 = 3 * 1366.
  localparam logic [13:0] DIV_BIAS   = 14'd4098;

  localparam step_t STEP_RESET [NUM_STEPPED] = '{8'd7, 8'd5, 8'd13, 8'd20};
  localparam pos_t  GOAL_RESET [NUM_JOINTS]  =
    '{11'd675, 11'd720, 11'd700, 11'd650, 11'd700, 11'd700};

  // 700 - 1366 + joint offset, added to the biased quotient.
  localparam logic signed [13:0] GOAL_BASE [NUM_JOINTS] =
    '{-14'sd691, -14'sd646, -14'sd666, -14'sd716, -14'sd666, -14'sd666};

endpackage

// File: rtl/six_joint_servo_ramp_core.sv
// ----------------------------------------------------------------------------
// six_joint_servo_ramp_core: slew-rate limiter for six servo positions
// Converts set-goal angles into clamped pulse goals and, on every tick
// transaction, ramps joints 0..3 toward them and moves joints 4 and 5 onto them.
// ----------------------------------------------------------------------------
//
// Usage:
//   The input channel (in_valid/in_ready) carries one transaction per item:
//   in_op selects a tick (advance all joints) or a set goal for in_joint with
//   in_angle in sixteenths of a degree. Every accepted transaction produces
//   exactly one result transaction on the output channel (out_valid/out_ready)
//   carrying the six current positions after the item took effect.
//   The configuration channel (cfg_valid/cfg_ready, always ready) writes the
//   coarse step of joints 0..3; indexes four and up are ignored. Write it only
//   while no transaction is in flight.
//   An accepted item is first captured in the input register; its effect then
//   lands in the position registers, which drive the result ports directly.
//   The block takes one transaction per cycle while the result receiver does
//   not stall; the goal conversion (one 14 by 17 bit multiply by the reciprocal
//   of three) and the ramp compare set the register-to-register path.
//   Reset puts every joint at 700, the goals at their rest values and the step
//   registers at 7, 5, 13 and 20. When the receiver stalls, the result holds
//   and the input register keeps one more item, after which in_ready drops.
//
module six_joint_servo_ramp_core
  import sjsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [2:0]  in_joint,
  input  logic signed [12:0] in_angle,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] out_pos_turn,
  output logic [10:0] out_pos_big,
  output logic [10:0] out_pos_medium,
  output logic [10:0] out_pos_small,
  output logic [10:0] out_pos_wrist,
  output logic [10:0] out_pos_paw,
  // Configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // Input register stage.
  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_op_r;
  joint_t      s1_joint_r;
  logic signed [12:0] s1_angle_r;

  logic        out_valid_r, out_valid_nxt;
  logic        advance;

  // Block state. The position registers double as the result register.
  pos_t  cur_r  [NUM_JOINTS];
  pos_t  cur_nxt[NUM_JOINTS];
  pos_t  goal_r [NUM_JOINTS];
  step_t step_r [NUM_STEPPED];

  // Goal conversion signals.
  logic [13:0]        div_num;
  logic [30:0]        div_prod;
  logic [11:0]        div_quot;
  logic               joint_ok;
  joint_t             joint_sel;
  logic signed [13:0] goal_raw;
  pos_t               goal_new;

  // Moves one joint toward its goal: a fine step of one when close,
  // otherwise the coarse step, which cannot overshoot.
  function automatic pos_t ramp(input pos_t cur, input pos_t goal, input step_t s);
    logic [11:0] gap;
    logic [11:0] lim;
    logic        fine;
    pos_t        delta;
    gap   = (goal < cur) ? 12'(cur - goal) : 12'(goal - cur);
    lim   = 12'({1'b0, s} + FINE_MARGIN);
    fine  = gap < lim;
    delta = fine ? 11'd1 : 11'(s);
    if (goal < cur) begin
      ramp = cur - delta;
    end else if (goal > cur) begin
      ramp = cur + delta;
    end else begin
      ramp = cur;
    end
  endfunction

  function automatic logic [13:0] in_angle_ext(input logic signed [12:0] a);
    in_angle_ext = 14'({a[12], a});
  endfunction

  // Handshake: the second stage moves when the result slot is free or drains.
  assign advance       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready      = !s1_valid_r || !out_valid_r || out_ready;
  assign s1_valid_nxt  = (in_valid && in_ready) || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_ready);
  assign cfg_ready     = 1'b1;

  // floor(angle / 3) through a biased, non-negative dividend.
  assign div_num   = 14'(in_angle_ext(s1_angle_r)) + DIV_BIAS;
  assign div_prod  = 31'(div_num) * 31'(RECIP3);
  assign div_quot  = div_prod[RECIP3_SHR +: 12];
  assign joint_ok  = s1_joint_r < JOINT_LIMIT;
  assign joint_sel = joint_ok ? s1_joint_r : '0;
  assign goal_raw  = $signed({2'b00, div_quot}) + GOAL_BASE[joint_sel];

  always_comb begin
    if (joint_sel == GRIPPER) begin
      if (goal_raw > $signed({3'b000, GRIP_MAX})) begin
        goal_new = GRIP_MAX;
      end else if (goal_raw < $signed({3'b000, GRIP_MIN})) begin
        goal_new = GRIP_MIN;
      end else begin
        goal_new = goal_raw[10:0];
      end
    end else begin
      if (goal_raw > $signed({3'b000, JOINT_MAX})) begin
        goal_new = JOINT_MAX;
      end else if (goal_raw < $signed({3'b000, JOINT_MIN})) begin
        goal_new = JOINT_MIN;
      end else begin
        goal_new = goal_raw[10:0];
      end
    end
  end

  // Tick update: ramped joints, then the two joints that follow their goal.
  always_comb begin
    for (int i = 0; i < NUM_STEPPED; i++) begin
      cur_nxt[i] = ramp(cur_r[i], goal_r[i], step_r[i]);
    end
    for (int i = NUM_STEPPED; i < NUM_JOINTS; i++) begin
      cur_nxt[i] = goal_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r    <= in_op;
      s1_joint_r <= in_joint;
      s1_angle_r <= in_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_JOINTS; i++) begin
        cur_r[i]  <= BASE_POS;
        goal_r[i] <= GOAL_RESET[i];
      end
    end else if (advance) begin
      if (s1_op_r == OP_TICK) begin
        for (int i = 0; i < NUM_JOINTS; i++) begin
          cur_r[i] <= cur_nxt[i];
        end
      end else if (joint_ok) begin
        goal_r[joint_sel] <= goal_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STEPPED; i++) begin
        step_r[i] <= STEP_RESET[i];
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STEP_TURN:   step_r[0] <= cfg_data;
        CFG_STEP_BIG:    step_r[1] <= cfg_data;
        CFG_STEP_MEDIUM: step_r[2] <= cfg_data;
        CFG_STEP_SMALL:  step_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pos_turn   = cur_r[0];
  assign out_pos_big    = cur_r[1];
  assign out_pos_medium = cur_r[2];
  assign out_pos_small  = cur_r[3];
  assign out_pos_wrist  = cur_r[4];
  assign out_pos_paw    = cur_r[5];

  // A stalled result must not be disturbed by items behind it.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(cur_r[0]) && $stable(cur_r[5]))
    else $error("positions changed while the result was stalled");

  // The input side only backs up when both stages are full and stalled.
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input throttled without a full stalled pipeline");

  // On a tick the wrist lands exactly on its goal.
  a_wrist_jump: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_op_r == OP_TICK |=> cur_r[4] == $past(goal_r[4]))
    else $error("wrist did not follow its goal on a tick");

  // The gripper goal stays inside its narrower clamp window.
  a_grip_range: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> goal_r[5] >= GRIP_MIN && goal_r[5] <= GRIP_MAX)
    else $error("gripper goal left its clamp range");

endmodule
